// ----- rtl/core/rqr_pkg.sv -----
// Shared types and codes for the ready queue with removal.
// No dependencies; imported by the cell modules and the top level.
package rqr_pkg;

    localparam int CMD_W  = 2;
    localparam int KIND_W = 3;
    localparam int OUT_ID_W = 8;

    localparam logic [CMD_W-1:0] CMD_YIELD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESUME = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TERM   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_DONE         = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DISPATCH     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RECLAIM      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EMPTY        = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FULL         = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RECLAIM_FULL = 3'd5;

    typedef struct packed {
        logic clear;
        logic sweep;
        logic pop;
        logic compact;
    } rqr_qctl_t;

    typedef struct packed {
        logic push;
        logic pop;
    } rqr_sctl_t;

endpackage

// ----- rtl/core/ready_queue_with_removal_core.sv -----
// Ready queue of thread ids with a reclaim stack, built as rows of cells.
// Yield and terminate of the running thread finish in ST_EXEC; resume emits R reclaimed ids
// (one per cycle unless the output is held), then appends; terminate of another thread sweeps
// the queue (removal flag ripples one cell per cycle), then compacts; a held output stalls.
// One item at a time; the next is accepted once the final result is registered. Reset
// (rst_n, asynchronous) clears counts, running id and control; slots are not cleared.
module ready_queue_with_removal_core
    import rqr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // thread_id[7:0], current_id[15:8]
    input  logic [2:0]  s_axis_tuser,   // cmd[1:0], thread_present[2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_id[7:0]
    output logic [2:0]  m_axis_tuser,   // kind[2:0]
    output logic        m_axis_tlast
);

    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SWEEP_W = $clog2(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(QUEUE_DEPTH);
    localparam logic [SWEEP_W-1:0] SWEEP_END = SWEEP_W'(QUEUE_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DRAIN,
        ST_SWEEP,
        ST_COMPACT
    } state_t;

    state_t              state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [ID_BITS-1:0]  tid_reg, tid_next;
    logic                present_reg, present_next;
    logic [ID_BITS-1:0]  cur_reg, cur_next;
    logic [CNT_W-1:0]    ready_count_reg, ready_count_next;
    logic [CNT_W-1:0]    reclaim_count_reg, reclaim_count_next;
    logic [ID_BITS-1:0]  running_id_reg, running_id_next;
    logic                running_valid_reg, running_valid_next;
    logic [SWEEP_W-1:0]  sweep_cnt_reg, sweep_cnt_next;
    logic                out_valid_reg;
    logic [KIND_W-1:0]   out_kind_reg;
    logic [OUT_ID_W-1:0] out_id_reg;
    logic                out_last_reg;

    logic                emit;
    logic [KIND_W-1:0]   emit_kind;
    logic [ID_BITS-1:0]  emit_id;
    logic                emit_last;
    logic                do_yield;
    logic                slot_free;
    logic                q_append;
    rqr_qctl_t           qctl;
    rqr_sctl_t           sctl;

    logic [ID_BITS-1:0]  q_id   [QUEUE_DEPTH];
    logic                q_flag [QUEUE_DEPTH];
    logic [ID_BITS-1:0]  s_id   [QUEUE_DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cells
            logic               q_prev_flag;
            logic [ID_BITS-1:0] q_next_id;
            logic [ID_BITS-1:0] s_prev_id;
            logic [ID_BITS-1:0] s_next_id;

            if (gi == 0)
            begin : g_first
                assign q_prev_flag = 1'b0;
                assign s_prev_id   = tid_reg;
            end
            else
            begin : g_mid
                assign q_prev_flag = q_flag[gi-1];
                assign s_prev_id   = s_id[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign q_next_id = '0;
                assign s_next_id = '0;
            end
            else
            begin : g_inner
                assign q_next_id = q_id[gi+1];
                assign s_next_id = s_id[gi+1];
            end

            rqr_queue_cell #(.ID_BITS(ID_BITS)) u_qcell (
                .clk       (clk),
                .ctl       (qctl),
                .load_en   (q_append && (ready_count_reg == CNT_W'(gi))),
                .load_id   (tid_reg),
                .match_id  (tid_reg),
                .occupied  (CNT_W'(gi) < ready_count_reg),
                .prev_flag (q_prev_flag),
                .next_id   (q_next_id),
                .id        (q_id[gi]),
                .flag      (q_flag[gi])
            );

            rqr_stack_cell #(.ID_BITS(ID_BITS)) u_scell (
                .clk     (clk),
                .ctl     (sctl),
                .prev_id (s_prev_id),
                .next_id (s_next_id),
                .id      (s_id[gi])
            );
        end
    endgenerate

    assign slot_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next         = state_reg;
        cmd_next           = cmd_reg;
        tid_next           = tid_reg;
        present_next       = present_reg;
        cur_next           = cur_reg;
        ready_count_next   = ready_count_reg;
        reclaim_count_next = reclaim_count_reg;
        running_id_next    = running_id_reg;
        running_valid_next = running_valid_reg;
        sweep_cnt_next     = sweep_cnt_reg;
        emit               = 1'b0;
        emit_kind          = KIND_DONE;
        emit_id            = '0;
        emit_last          = 1'b1;
        do_yield           = 1'b0;
        q_append           = 1'b0;
        qctl               = '0;
        sctl               = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next     = s_axis_tuser[1:0];
                    present_next = s_axis_tuser[2];
                    tid_next     = ID_BITS'(s_axis_tdata[7:0]);
                    cur_next     = ID_BITS'(s_axis_tdata[15:8]);
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                priority if (cmd_reg == CMD_RESUME)
                begin
                    state_next = ST_DRAIN;
                end
                else if (cmd_reg == CMD_YIELD)
                begin
                    do_yield = slot_free;
                end
                else if (cmd_reg == CMD_TERM && present_reg
                         && reclaim_count_reg != CNT_FULL && tid_reg != cur_reg)
                begin
                    qctl.clear     = 1'b1;
                    sweep_cnt_next = '0;
                    state_next     = ST_SWEEP;
                end
                else if (slot_free)
                begin
                    if (cmd_reg == CMD_TERM && present_reg)
                    begin
                        if (reclaim_count_reg == CNT_FULL)
                        begin
                            emit       = 1'b1;
                            emit_kind  = KIND_RECLAIM_FULL;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            sctl.push          = 1'b1;
                            reclaim_count_next = reclaim_count_reg + 1'b1;
                            do_yield           = 1'b1;
                        end
                    end
                    else
                    begin
                        emit       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    if (reclaim_count_reg != '0)
                    begin
                        emit_kind          = KIND_RECLAIM;
                        emit_id            = s_id[0];
                        emit_last          = 1'b0;
                        sctl.pop           = 1'b1;
                        reclaim_count_next = reclaim_count_reg - 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                        if (present_reg)
                        begin
                            if (ready_count_reg == CNT_FULL)
                            begin
                                emit_kind = KIND_FULL;
                            end
                            else
                            begin
                                q_append         = 1'b1;
                                ready_count_next = ready_count_reg + 1'b1;
                            end
                        end
                    end
                end
            end
            ST_SWEEP:
            begin
                qctl.sweep     = 1'b1;
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (sweep_cnt_reg == SWEEP_END)
                begin
                    state_next = ST_COMPACT;
                end
            end
            ST_COMPACT:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if (q_flag[QUEUE_DEPTH-1])
                    begin
                        qctl.compact       = 1'b1;
                        ready_count_next   = ready_count_reg - 1'b1;
                        sctl.push          = 1'b1;
                        reclaim_count_next = reclaim_count_reg + 1'b1;
                    end
                    else if (running_valid_reg && tid_reg == running_id_reg)
                    begin
                        sctl.push          = 1'b1;
                        reclaim_count_next = reclaim_count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_yield)
        begin
            emit       = 1'b1;
            state_next = ST_IDLE;
            if (ready_count_reg == '0)
            begin
                emit_kind = KIND_EMPTY;
            end
            else
            begin
                emit_kind          = KIND_DISPATCH;
                emit_id            = q_id[0];
                qctl.pop           = 1'b1;
                ready_count_next   = ready_count_reg - 1'b1;
                running_id_next    = q_id[0];
                running_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            ready_count_reg   <= '0;
            reclaim_count_reg <= '0;
            running_id_reg    <= '0;
            running_valid_reg <= 1'b0;
            sweep_cnt_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            ready_count_reg   <= ready_count_next;
            reclaim_count_reg <= reclaim_count_next;
            running_id_reg    <= running_id_next;
            running_valid_reg <= running_valid_next;
            sweep_cnt_reg     <= sweep_cnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        tid_reg     <= tid_next;
        present_reg <= present_next;
        cur_reg     <= cur_next;
        if (emit)
        begin
            out_kind_reg <= emit_kind;
            out_id_reg   <= OUT_ID_W'(emit_id);
            out_last_reg <= emit_last;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_id_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_ready_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ready_count_reg <= CNT_FULL)
        else $error("ready count beyond queue depth");

    a_reclaim_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        reclaim_count_reg <= CNT_FULL)
        else $error("reclaim count beyond stack depth");

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item accepted while one is in progress");

    a_reclaim_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_RECLAIM |-> !m_axis_tlast)
        else $error("reclaim item marked last");

    a_dispatch_sets_running: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_DISPATCH |-> running_valid_reg)
        else $error("dispatch without running thread recorded");
`endif

endmodule

// ----- rtl/core/rqr_queue_cell.sv -----
// One slot of the ready queue: holds an id and a removal flag.
// Depends on rqr_pkg for the control struct.
module rqr_queue_cell
    import rqr_pkg::*;
#(
    parameter int ID_BITS = 8
)
(
    input  logic               clk,
    input  rqr_qctl_t          ctl,
    input  logic               load_en,
    input  logic [ID_BITS-1:0] load_id,
    input  logic [ID_BITS-1:0] match_id,
    input  logic               occupied,
    input  logic               prev_flag,
    input  logic [ID_BITS-1:0] next_id,
    output logic [ID_BITS-1:0] id,
    output logic               flag
);

    logic [ID_BITS-1:0] id_reg;
    logic [ID_BITS-1:0] id_next;
    logic               flag_reg;
    logic               flag_next;

    always_comb
    begin
        id_next = id_reg;
        if (load_en)
        begin
            id_next = load_id;
        end
        else if (ctl.pop || (ctl.compact && flag_reg))
        begin
            id_next = next_id;
        end
    end

    always_comb
    begin
        flag_next = flag_reg;
        if (ctl.clear)
        begin
            flag_next = 1'b0;
        end
        else if (ctl.sweep)
        begin
            flag_next = prev_flag || (occupied && (id_reg == match_id));
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        flag_reg <= flag_next;
    end

    assign id   = id_reg;
    assign flag = flag_reg;

endmodule

// ----- rtl/core/rqr_stack_cell.sv -----
// One slot of the reclaim stack: shifts deeper on push, shallower on pop.
// Depends on rqr_pkg for the control struct.
module rqr_stack_cell
    import rqr_pkg::*;
#(
    parameter int ID_BITS = 8
)
(
    input  logic               clk,
    input  rqr_sctl_t          ctl,
    input  logic [ID_BITS-1:0] prev_id,
    input  logic [ID_BITS-1:0] next_id,
    output logic [ID_BITS-1:0] id
);

    logic [ID_BITS-1:0] id_reg;
    logic [ID_BITS-1:0] id_next;

    always_comb
    begin
        id_next = id_reg;
        if (ctl.push)
        begin
            id_next = prev_id;
        end
        else if (ctl.pop)
        begin
            id_next = next_id;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id = id_reg;

endmodule
